FILE: design/hcvg_pkg.sv
// shared types, constants and helper functions for the hex cell vertex generator
package hcvg_pkg;

  localparam int unsigned MAX_GRID_DIM = 256;
  localparam int unsigned NUM_CORNERS  = 6;
  localparam int unsigned CORNER_W     = $clog2(NUM_CORNERS);

  localparam int unsigned CELL_W  = 8;
  localparam int unsigned GW_W    = 9;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned TEX_W   = 13;
  localparam int unsigned IDX_W   = 19;
  localparam int unsigned LIN_W   = 16;

  typedef logic [CORNER_W-1:0] corner_t;
  localparam corner_t LAST_CORNER = corner_t'(NUM_CORNERS - 1);

  // texture quadrant origin, half of the 0x1000 texture span
  localparam logic [TEX_W-1:0] TEX_HALF = TEX_W'(13'h1000 >> 1);

  typedef enum logic [1:0] {
    REG_GRID_WIDTH = 2'd0,
    REG_HEX_SIZE   = 2'd1,
    REG_ROW_STEP   = 2'd2,
    REG_TEX_SCALE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GW_W-1:0]  grid_width;
    logic [CFG_W-1:0] hex_size;
    logic [CFG_W-1:0] row_step;
    logic [CFG_W-1:0] tex_scale;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [TEX_W-1:0]   u0;
    logic [TEX_W-1:0]   v0;
    logic [IDX_W-1:0]   base;
  } cell_t;

  // residue mod 3 via base-4 digit sums
  function automatic logic [1:0] mod3(input logic [GW_W-1:0] x);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]) + 4'(x[8]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // x * {3,4,3,1,0,1}[c] / 4
  function automatic logic [CFG_W-1:0] quarter_off(input logic [CFG_W-1:0] x,
                                                    input corner_t c);
    logic [CFG_W+1:0] x3;
    logic [CFG_W-1:0] r;
    x3 = {2'b00, x} + {1'b0, x, 1'b0};
    case (c)
      3'd0, 3'd2: r = x3[CFG_W+1:2];
      3'd1:       r = x;
      3'd3, 3'd5: r = {2'b00, x[CFG_W-1:2]};
      default:    r = '0;
    endcase
    return r;
  endfunction

  // x * {0,1,2,2,1,0}[c] / 2
  function automatic logic [CFG_W-1:0] half_off(input logic [CFG_W-1:0] x,
                                                 input corner_t c);
    logic [CFG_W-1:0] r;
    case (c)
      3'd1, 3'd4: r = {1'b0, x[CFG_W-1:1]};
      3'd2, 3'd3: r = x;
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/hex_cell_vertex_generator_top.sv
// top level of the flat-top hex cell vertex generator
// path: a cell passes the input register, the cell register, then the output register
// the corner sequencer sends the six corners of each cell on the single output port
// input register, cell register and output register overlap, so the next cell waits in place
// reset: asynchronous active low, clears valid flags and loads register defaults
module hex_cell_vertex_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [hcvg_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hcvg_pkg::CELL_W-1:0]  cell_col_i,
  input  logic [hcvg_pkg::CELL_W-1:0]  cell_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [hcvg_pkg::COORD_W-1:0] vertex_x_o,
  output logic signed [hcvg_pkg::COORD_W-1:0] vertex_y_o,
  output logic [hcvg_pkg::TEX_W-1:0]   tex_u_o,
  output logic [hcvg_pkg::TEX_W-1:0]   tex_v_o,
  output logic [hcvg_pkg::IDX_W-1:0]   vertex_index_o,
  output logic                         last_o
);
  import hcvg_pkg::*;

  cfg_t               cfg;
  cell_t              cell_info;
  logic               cell_valid;
  logic               take;
  logic [COORD_W-1:0] vx, vy;

  hcvg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcvg_cell u_cell (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_col_i   (cell_col_i),
    .cell_row_i   (cell_row_i),
    .cfg_i        (cfg),
    .take_i       (take),
    .cell_valid_o (cell_valid),
    .cell_o       (cell_info)
  );

  hcvg_corner u_corner (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cell_valid_i   (cell_valid),
    .cell_i         (cell_info),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_x_o     (vx),
    .vertex_y_o     (vy),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .vertex_index_o (vertex_index_o),
    .last_o         (last_o)
  );

  assign vertex_x_o = $signed(vx);
  assign vertex_y_o = $signed(vy);

  // corners of one cell follow each other without gaps when the sink keeps taking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("corner sequence broke before the last corner");

  // back-to-back corner transfers of one cell step the buffer index by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((out_valid_o && !out_stall_i && !last_o) ##1 (out_valid_o && !out_stall_i))
    |-> (vertex_index_o == $past(vertex_index_o) + IDX_W'(1)))
    else $error("vertex index did not advance by one between corners");

endmodule

FILE: design/hcvg_cfg.sv
// configuration register bank with grid width clamp
module hcvg_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [hcvg_pkg::CFG_W-1:0] cfg_data_i,
  output hcvg_pkg::cfg_t            cfg_o
);
  import hcvg_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [GW_W-1:0]  gw_val;

  always_comb begin
    gw_val = cfg_data_i[GW_W-1:0];
    cfg_d  = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GRID_WIDTH: begin
          cfg_d.grid_width = (gw_val > GW_W'(MAX_GRID_DIM)) ? GW_W'(MAX_GRID_DIM) : gw_val;
        end
        REG_HEX_SIZE:  cfg_d.hex_size  = cfg_data_i;
        REG_ROW_STEP:  cfg_d.row_step  = cfg_data_i;
        REG_TEX_SCALE: cfg_d.tex_scale = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width <= GW_W'(16);
      cfg_q.hex_size   <= CFG_W'(64);
      cfg_q.row_step   <= CFG_W'(56);
      cfg_q.tex_scale  <= CFG_W'(2048);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/hcvg_cell.sv
// input register and per-cell origin, quadrant and index computation
module hcvg_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hcvg_pkg::CELL_W-1:0] cell_col_i,
  input  logic [hcvg_pkg::CELL_W-1:0] cell_row_i,
  input  hcvg_pkg::cfg_t              cfg_i,
  input  logic                        take_i,
  output logic                        cell_valid_o,
  output hcvg_pkg::cell_t             cell_o
);
  import hcvg_pkg::*;

  logic              valid_q, valid_d;
  logic [CELL_W-1:0] col_q, row_q;
  logic              load;

  logic [CFG_W+1:0]    hs3;
  logic [CFG_W-1:0]    colstep_raw, colstep;
  logic [19:0]         xprod, yprod;
  logic [GW_W+CELL_W-1:0] wprod;
  logic [LIN_W-1:0]    lin;
  logic [1:0]          quad;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q <= cell_col_i;
      row_q <= cell_row_i;
    end
  end

  // column pitch is 3/4 of the hex size, truncated, then rounded up to even
  always_comb begin
    hs3         = {2'b00, cfg_i.hex_size} + {1'b0, cfg_i.hex_size, 1'b0};
    colstep_raw = hs3[CFG_W+1:2];
    colstep     = colstep_raw + CFG_W'(colstep_raw[0]);
    xprod       = 20'(col_q) * 20'(colstep);
    yprod       = 20'(row_q) * 20'(cfg_i.row_step);
    wprod       = (GW_W+CELL_W)'(row_q) * (GW_W+CELL_W)'(cfg_i.grid_width);
    lin         = wprod[LIN_W-1:0] + LIN_W'(col_q);
    quad        = mod3(GW_W'(col_q) + GW_W'(row_q));

    cell_o.ox   = COORD_W'(cfg_i.hex_size) + xprod[COORD_W-1:0];
    cell_o.oy   = yprod[COORD_W-1:0]
                + (col_q[0] ? COORD_W'(cfg_i.row_step[CFG_W-1:1]) : '0);
    cell_o.base = IDX_W'({lin, 2'b00}) + IDX_W'({lin, 1'b0});
    case (quad)
      2'd0: begin
        cell_o.u0 = TEX_HALF;
        cell_o.v0 = '0;
      end
      2'd1: begin
        cell_o.u0 = '0;
        cell_o.v0 = TEX_HALF;
      end
      default: begin
        cell_o.u0 = TEX_HALF;
        cell_o.v0 = TEX_HALF;
      end
    endcase
  end

  assign cell_valid_o = valid_q;

endmodule

FILE: design/hcvg_corner.sv
// corner sequencer and vertex output register
module hcvg_corner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcvg_pkg::cfg_t               cfg_i,
  input  logic                         cell_valid_i,
  input  hcvg_pkg::cell_t              cell_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hcvg_pkg::COORD_W-1:0] vertex_x_o,
  output logic [hcvg_pkg::COORD_W-1:0] vertex_y_o,
  output logic [hcvg_pkg::TEX_W-1:0]   tex_u_o,
  output logic [hcvg_pkg::TEX_W-1:0]   tex_v_o,
  output logic [hcvg_pkg::IDX_W-1:0]   vertex_index_o,
  output logic                         last_o
);
  import hcvg_pkg::*;

  logic    cur_valid_q, cur_valid_d;
  cell_t   cur_q;
  corner_t corner_q, corner_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free, step, done, load;

  logic [COORD_W-1:0] x_d, y_d;
  logic [TEX_W-1:0]   u_d, v_d;
  logic [IDX_W-1:0]   idx_d;
  logic               last_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = cur_valid_q && out_free;
  assign done     = step && (corner_q == LAST_CORNER);
  assign take_o   = !cur_valid_q || done;
  assign load     = take_o && cell_valid_i;

  always_comb begin
    if (load) begin
      cur_valid_d = 1'b1;
    end else if (done) begin
      cur_valid_d = 1'b0;
    end else begin
      cur_valid_d = cur_valid_q;
    end

    if (load || done) begin
      corner_d = '0;
    end else if (step) begin
      corner_d = corner_q + corner_t'(1);
    end else begin
      corner_d = corner_q;
    end

    out_valid_d = step || (out_valid_q && out_stall_i);
  end

  always_comb begin
    x_d    = cur_q.ox - COORD_W'(quarter_off(cfg_i.hex_size, corner_q));
    y_d    = cur_q.oy + COORD_W'(half_off(cfg_i.row_step, corner_q));
    u_d    = cur_q.u0 + TEX_W'(quarter_off(cfg_i.tex_scale, corner_q));
    v_d    = cur_q.v0 + TEX_W'(half_off(cfg_i.tex_scale, corner_q));
    idx_d  = cur_q.base + IDX_W'(corner_q);
    last_d = (corner_q == LAST_CORNER);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cell_i;
    end
    if (step) begin
      vertex_x_o     <= x_d;
      vertex_y_o     <= y_d;
      tex_u_o        <= u_d;
      tex_v_o        <= v_d;
      vertex_index_o <= idx_d;
      last_o         <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
